/* hw/rtl/phb_cfg_pkg.sv */
// types and constants for the host bridge configuration space block
// no dependencies; imported by pci_host_bridge_config_space_core
package phb_cfg_pkg;

    // request targets on the bridge register bus
    typedef enum logic [3:0] {
        TGT_CFG_ADDR  = 4'd0,
        TGT_CFG_DATA  = 4'd1,
        TGT_ARB_INT   = 4'd2,
        TGT_ARB_INTEN = 4'd3,
        TGT_MISC      = 4'd4,
        TGT_ID        = 4'd5,
        TGT_CLASS     = 4'd6,
        TGT_SUBSYS    = 4'd7,
        TGT_PIN_GNT   = 4'd8
    } t_target;

    // configuration register indexes
    typedef enum logic {
        CFG_LANE_SWAP  = 1'b0,
        CFG_BRIDGE_DEV = 1'b1
    } t_cfg_index;

    // header dword numbers
    localparam logic [5:0] DW_ID         = 6'd0;
    localparam logic [5:0] DW_STATUS_CMD = 6'd1;
    localparam logic [5:0] DW_CLASS      = 6'd2;
    localparam logic [5:0] DW_LAT        = 6'd3;
    localparam logic [5:0] DW_BAR0       = 6'd4;
    localparam logic [5:0] DW_SUBSYS     = 6'd11;
    localparam logic [5:0] DW_INTR       = 6'd15;

    localparam int unsigned NUM_BARS = 6;

    localparam logic [31:0] BAR_SIZE_MASK [NUM_BARS] = '{
        32'hf000_0000, 32'hfc00_0000, 32'hff00_0000,
        32'hffc0_0000, 32'hfff0_0000, 32'hfffc_0000
    };

    // reset values and write masks
    localparam logic [31:0] ID_RESET         = 32'h00c4_114f;
    localparam logic [31:0] CLASS_RESET      = 32'h0600_0000;
    localparam logic [23:0] PIN_GNT_RESET    = 24'h00_0601;
    localparam logic [7:0]  LAT_RESET        = 8'd64;
    localparam logic [9:0]  MISC_WR_MASK     = 10'h3f1;
    localparam int unsigned MISC_BAR_EN_LSB  = 4;
    localparam logic [31:0] STATUS_CMD_WORD  = 32'h0880_0006;
    localparam logic [2:0]  SIZE_WORD        = 3'd4;
    localparam logic [7:0]  BUS_ROOT         = 8'd0;
    localparam logic [2:0]  FUNC_BRIDGE      = 3'd0;
    localparam logic [1:0]  CFG_TYPE0        = 2'd0;

endpackage

/* hw/rtl/pci_host_bridge_config_space_core.sv */
// Host bridge register block with its own type-0 configuration header.
// Takes one register request per clock while the output register is free and
// returns its read data in the cycle after acceptance through that register;
// o_in_ready stays high while that register is empty or being taken, so a request
// can follow in every cycle, decoded and applied in the single decode-and-update
// stage. All state but the read data is in flip-flops reset directly, so there is
// no clearing pass after reset. Reads of another device, a wrong config type or an
// unused target return zero; writes return zero. Depends on phb_cfg_pkg.
module pci_host_bridge_config_space_core
    import phb_cfg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [3:0]  i_target,
    input  logic [1:0]  i_byte_offset,
    input  logic [2:0]  i_access_size,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data
);

    // architectural state
    logic        r_lane_swap;
    logic [4:0]  r_bridge_dev;
    logic [31:0] r_cfg_addr;
    logic [31:0] r_id;
    logic [31:0] r_class;
    logic [31:0] r_subsys;
    logic [23:0] r_pin_gnt;
    logic [7:0]  r_lat;
    logic [7:0]  r_int_line;
    logic [31:0] r_bar [NUM_BARS];
    logic [9:0]  r_misc;
    logic [5:0]  r_arb_int;
    logic [5:0]  r_arb_inten;
    logic        r_out_valid;
    logic [31:0] r_read_data;

    logic [31:0] n_cfg_addr;
    logic [31:0] n_id;
    logic [31:0] n_class;
    logic [31:0] n_subsys;
    logic [23:0] n_pin_gnt;
    logic [7:0]  n_lat;
    logic [7:0]  n_int_line;
    logic [31:0] n_bar [NUM_BARS];
    logic [9:0]  n_misc;
    logic [5:0]  n_arb_int;
    logic [5:0]  n_arb_inten;
    logic [31:0] n_read_data;

    logic        in_acc;
    logic        wr;
    logic [2:0]  size_n;
    logic [1:0]  off_eff;
    logic [4:0]  sh;
    logic [31:0] size_mask;
    logic [31:0] lane_mask;
    logic [31:0] wdata_sh;
    logic [5:0]  dw;
    logic        sel_bridge;
    logic [31:0] hdr;
    logic [31:0] rd;
    logic        bar_clean;

    // handshake: output register frees up as it is taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign wr          = i_kind;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    // size normalisation: a code of zero or above a word acts as a full word
    always_comb begin
        if (i_access_size == 3'd0 || i_access_size > SIZE_WORD) begin
            size_n = SIZE_WORD;
        end else begin
            size_n = i_access_size;
        end
    end

    // lane swizzle for swapped byte order
    always_comb begin
        off_eff = i_byte_offset;
        if (r_lane_swap) begin
            if (size_n == 3'd1) begin
                off_eff = i_byte_offset ^ 2'd3;
            end else if (size_n == 3'd2) begin
                off_eff = i_byte_offset ^ 2'd2;
            end
        end
    end

    // byte-lane mask and shifted write data
    always_comb begin
        unique case (size_n)
            3'd1:    size_mask = 32'h0000_00ff;
            3'd2:    size_mask = 32'h0000_ffff;
            3'd3:    size_mask = 32'h00ff_ffff;
            default: size_mask = 32'hffff_ffff;
        endcase
    end

    assign sh        = {off_eff, 3'b000};
    assign lane_mask = size_mask << sh;
    assign wdata_sh  = i_write_data << sh;
    assign dw        = r_cfg_addr[7:2];

    // config address selects the bridge itself
    assign sel_bridge = (r_cfg_addr[23:16] == BUS_ROOT) && (r_cfg_addr[1:0] == CFG_TYPE0)
                     && (r_cfg_addr[15:11] == r_bridge_dev)
                     && (r_cfg_addr[10:8] == FUNC_BRIDGE);

    // header dword read
    always_comb begin
        hdr = '0;
        if (dw == DW_ID) begin
            hdr = r_id;
        end else if (dw == DW_STATUS_CMD) begin
            hdr = STATUS_CMD_WORD;
        end else if (dw == DW_CLASS) begin
            hdr = r_class;
        end else if (dw == DW_LAT) begin
            hdr = {16'd0, r_lat, 8'd0};
        end else if (dw == DW_SUBSYS) begin
            hdr = r_subsys;
        end else if (dw == DW_INTR) begin
            hdr = {r_pin_gnt, r_int_line};
        end
        for (int i = 0; i < NUM_BARS; i++) begin
            if (dw == DW_BAR0 + 6'(i) && r_misc[MISC_BAR_EN_LSB + i]) begin
                hdr = r_bar[i];
            end
        end
    end

    // request decode and next state
    always_comb begin
        n_cfg_addr  = r_cfg_addr;
        n_id        = r_id;
        n_class     = r_class;
        n_subsys    = r_subsys;
        n_pin_gnt   = r_pin_gnt;
        n_lat       = r_lat;
        n_int_line  = r_int_line;
        n_bar       = r_bar;
        n_misc      = r_misc;
        n_arb_int   = r_arb_int;
        n_arb_inten = r_arb_inten;
        rd          = '0;
        unique case (t_target'(i_target))
            TGT_CFG_ADDR: begin
                if (size_n != SIZE_WORD) begin
                    rd = '1;
                end else if (wr) begin
                    n_cfg_addr = i_write_data;
                end else begin
                    rd = r_cfg_addr;
                end
            end
            TGT_CFG_DATA: begin
                if (sel_bridge) begin
                    if (wr) begin
                        for (int i = 0; i < NUM_BARS; i++) begin
                            if (dw == DW_BAR0 + 6'(i) && r_misc[MISC_BAR_EN_LSB + i]) begin
                                n_bar[i] = (r_bar[i] & ~lane_mask)
                                         | (wdata_sh & BAR_SIZE_MASK[i] & lane_mask);
                            end
                        end
                        if (dw == DW_LAT && lane_mask[15:8] != 8'd0) begin
                            n_lat = wdata_sh[15:8];
                        end
                        if (dw == DW_INTR && lane_mask[7:0] != 8'd0) begin
                            n_int_line = wdata_sh[7:0];
                        end
                    end else begin
                        rd = (hdr & lane_mask) >> sh;
                    end
                end
            end
            TGT_ARB_INT: begin
                if (wr) n_arb_int = r_arb_int ^ i_write_data[5:0];
                else    rd = {26'd0, r_arb_int};
            end
            TGT_ARB_INTEN: begin
                if (wr) n_arb_inten = i_write_data[5:0];
                else    rd = {26'd0, r_arb_inten};
            end
            TGT_MISC: begin
                if (wr) n_misc = i_write_data[9:0] & MISC_WR_MASK;
                else    rd = {22'd0, r_misc};
            end
            TGT_ID: begin
                if (wr) n_id = i_write_data;
                else    rd = r_id;
            end
            TGT_CLASS: begin
                if (wr) n_class = i_write_data;
                else    rd = r_class;
            end
            TGT_SUBSYS: begin
                if (wr) n_subsys = i_write_data;
                else    rd = r_subsys;
            end
            TGT_PIN_GNT: begin
                if (wr) n_pin_gnt = i_write_data[23:0];
                else    rd = {8'd0, r_pin_gnt};
            end
            default: begin
                rd = '0;
            end
        endcase
        n_read_data = wr ? '0 : rd;
    end

    // state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_swap  <= 1'b0;
            r_bridge_dev <= '0;
            r_cfg_addr   <= '0;
            r_id         <= ID_RESET;
            r_class      <= CLASS_RESET;
            r_subsys     <= '0;
            r_pin_gnt    <= PIN_GNT_RESET;
            r_lat        <= LAT_RESET;
            r_int_line   <= '0;
            r_bar        <= BAR_SIZE_MASK;
            r_misc       <= '0;
            r_arb_int    <= '0;
            r_arb_inten  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_LANE_SWAP:  r_lane_swap  <= i_cfg_data[0];
                    CFG_BRIDGE_DEV: r_bridge_dev <= i_cfg_data;
                    default:        r_lane_swap  <= r_lane_swap;
                endcase
            end
            if (in_acc) begin
                r_cfg_addr  <= n_cfg_addr;
                r_id        <= n_id;
                r_class     <= n_class;
                r_subsys    <= n_subsys;
                r_pin_gnt   <= n_pin_gnt;
                r_lat       <= n_lat;
                r_int_line  <= n_int_line;
                r_bar       <= n_bar;
                r_misc      <= n_misc;
                r_arb_int   <= n_arb_int;
                r_arb_inten <= n_arb_inten;
                r_read_data <= n_read_data;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bars never hold bits below their size
    always_comb begin
        bar_clean = 1'b1;
        for (int i = 0; i < NUM_BARS; i++) begin
            if ((r_bar[i] & ~BAR_SIZE_MASK[i]) != 32'd0) begin
                bar_clean = 1'b0;
            end
        end
    end

    a_bar_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n) bar_clean)
        else $error("bar holds bits below its size mask");

    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_kind) |=> (o_out_valid && o_read_data == 32'd0))
        else $error("write request returned non-zero data");

    a_misc_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_misc & ~MISC_WR_MASK) == 10'd0)
        else $error("misc control reserved bits set");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted request gave no result");

endmodule
